// ===== hdl/srda_pkg.sv =====
package srda_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1,
    CFG_ACCEL = 2'd2
  } cfg_idx_e;

  // register reset values (inner 0.1, outer 0.99 in Q1.15, shape 1.0 in Q8.8)
  localparam logic [CFG_DATA_W-1:0] INNER_RST = 16'd3277;
  localparam logic [CFG_DATA_W-1:0] OUTER_RST = 16'd32440;
  localparam logic [CFG_DATA_W-1:0] ACCEL_RST = 16'd256;

endpackage

// ===== hdl/srda_in_if.sv =====
interface srda_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic signed [SAMPLE_BITS-1:0] raw_y;

  modport source (output valid, raw_x, raw_y, input ready);
  modport sink   (input valid, raw_x, raw_y, output ready);
endinterface

// ===== hdl/srda_out_if.sv =====
interface srda_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_x;
  logic signed [SAMPLE_BITS-1:0] out_y;
  logic [SAMPLE_BITS-1:0]        mag_before_accel;
  logic [SAMPLE_BITS-1:0]        mag_after_accel;

  modport source (output valid, out_x, out_y, mag_before_accel, mag_after_accel, input ready);
  modport sink   (input valid, out_x, out_y, mag_before_accel, mag_after_accel, output ready);
endinterface

// ===== hdl/srda_sqrt_cell.sv =====
module srda_sqrt_cell #(
  parameter int unsigned RW  = 19,
  parameter int unsigned QW  = 16,
  parameter int unsigned SRW = 32,
  parameter int unsigned SW  = 34
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [RW-1:0]  rem_i,
  input  logic [QW-1:0]  root_i,
  input  logic [SRW-1:0] src_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [RW-1:0]  rem_o,
  output logic [QW-1:0]  root_o,
  output logic [SRW-1:0] src_o,
  output logic [SW-1:0]  side_o
);

  logic [RW+1:0] r2;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;
  logic [RW-1:0] rem_d;
  logic [QW-1:0] root_d;

  // one root bit: bring down two radicand bits, try 4*root+1
  assign r2     = {rem_i, src_i[SRW-1:SRW-2]};
  assign trial  = (RW+2)'({root_i, 2'b01});
  assign ge     = r2 >= trial;
  assign diff   = r2 - trial;
  assign rem_d  = ge ? diff[RW-1:0] : r2[RW-1:0];
  assign root_d = {root_i[QW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      src_o  <= src_i << 2;
      side_o <= side_i;
    end
  end

endmodule

// ===== hdl/srda_div_cell.sv =====
module srda_div_cell #(
  parameter int unsigned DW = 16,
  parameter int unsigned NW = 16,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;

  // one quotient bit of restoring division
  assign r2    = {rem_i, num_i[NW-1]};
  assign ge    = r2 >= {1'b0, den_i};
  assign diff  = r2 - {1'b0, den_i};
  assign rem_d = ge ? diff[DW-1:0] : r2[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      num_o  <= num_i << 1;
      den_o  <= den_i;
      quo_o  <= {quo_i[QW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

// ===== hdl/stick_radial_deadzone_accel_core.sv =====
// channel  | dir | payload                                           | handshake
// in_i     | in  | raw_x, raw_y                                      | valid/ready
// out_o    | out | out_x, out_y, mag_before_accel, mag_after_accel   | valid/ready
// cfg      | in  | cfg_idx_i, cfg_data_i                             | cfg_we_i
//
// one transaction per cycle while the output is not stalled; 4*SAMPLE_BITS+4 register stages from input to
// output: the square root row, the three divider rows (the two axis rows run
// side by side) and five datapath stages including the output register.
// each cell resolves one root or quotient bit per cycle.
// reset clears all valid bits and loads the register defaults.
// a stalled output freezes every stage; ready is high whenever the output
// register is empty or being taken.
module stick_radial_deadzone_accel_core #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srda_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srda_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  srda_in_if.sink                             in_i,
  srda_out_if.source                          out_o
);
  import srda_pkg::*;

  localparam int unsigned N    = SAMPLE_BITS;
  localparam int unsigned F    = N - 1;
  localparam int unsigned IW   = (F >= 15) ? F + 1 : 16;
  localparam int unsigned AQW  = N + 7;
  localparam int unsigned DW2  = N + 8;
  localparam int unsigned PW   = 2 * N + 8;
  localparam int unsigned RW   = N + 2;
  localparam int unsigned SQSW = 2 + 2 * N;
  localparam int unsigned D1SW = 4 + 3 * N;
  localparam int unsigned D2SW = 3 + 4 * N;
  localparam int unsigned D3SW = 2 + 2 * N;
  localparam logic [N-1:0]   ONE   = N'(1) << F;
  localparam logic [N-1:0]   SAT   = ONE - N'(1);
  localparam logic [DW2-1:0] ONE_W = DW2'(1) << F;

  logic en;

  // configuration registers
  logic [CFG_DATA_W-1:0] inner_q, outer_q, accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_RST;
      outer_q <= OUTER_RST;
      accel_q <= ACCEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INNER: inner_q <= cfg_data_i;
        CFG_OUTER: outer_q <= cfg_data_i;
        CFG_ACCEL: accel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // radii in sample scale, shape in sample scale
  logic [IW-1:0]   inner_s, outer_s;
  logic [F+15:0]   aq_full;
  logic [AQW-1:0]  aq;

  if (F >= 15) begin : g_up
    assign inner_s = IW'(inner_q) << (F - 15);
    assign outer_s = IW'(outer_q) << (F - 15);
  end else begin : g_down
    assign inner_s = IW'(inner_q >> (15 - F));
    assign outer_s = IW'(outer_q >> (15 - F));
  end
  assign aq_full = {accel_q, {F{1'b0}}};
  assign aq      = aq_full[F+15:8];

  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage a: magnitudes and squared length
  logic [N-1:0]   ax_c, ay_c;
  logic [2*N-1:0] sq_c;
  logic           va_q, sxa_q, sya_q;
  logic [N-1:0]   axa_q, aya_q;
  logic [2*N-1:0] sqa_q;

  assign ax_c = in_i.raw_x[N-1] ? (~in_i.raw_x + N'(1)) : in_i.raw_x;
  assign ay_c = in_i.raw_y[N-1] ? (~in_i.raw_y + N'(1)) : in_i.raw_y;
  assign sq_c = ax_c * ax_c + ay_c * ay_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxa_q <= in_i.raw_x[N-1];
      sya_q <= in_i.raw_y[N-1];
      axa_q <= ax_c;
      aya_q <= ay_c;
      sqa_q <= sq_c;
    end
  end

  // square root row
  logic            sq_v    [0:N];
  logic [RW-1:0]   sq_rem  [0:N];
  logic [N-1:0]    sq_root [0:N];
  logic [2*N-1:0]  sq_src  [0:N];
  logic [SQSW-1:0] sq_side [0:N];

  assign sq_v[0]    = va_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_src[0]  = sqa_q;
  assign sq_side[0] = {sxa_q, sya_q, axa_q, aya_q};

  for (genvar i = 0; i < N; i++) begin : g_sqrt
    srda_sqrt_cell #(.RW(RW), .QW(N), .SRW(2 * N), .SW(SQSW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_v[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]),
      .src_i(sq_src[i]), .side_i(sq_side[i]),
      .valid_o(sq_v[i+1]), .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]),
      .src_o(sq_src[i+1]), .side_o(sq_side[i+1])
    );
  end

  // stage b: deadzone and limit tests, divider operands
  logic         sxb_c, syb_c;
  logic [N-1:0] axb_c, ayb_c, m_c;
  logic         vb_q, dzb_q, fullb_q, sxb_q, syb_q;
  logic [N-1:0] axb_q, ayb_q, mb_q;
  logic [IW-1:0] nb_q, db_q;

  assign {sxb_c, syb_c, axb_c, ayb_c} = sq_side[N];
  assign m_c = sq_root[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= sq_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dzb_q   <= IW'(m_c) <= inner_s;
      fullb_q <= IW'(m_c) >= outer_s;
      nb_q    <= IW'(m_c) - inner_s;
      db_q    <= outer_s - inner_s;
      sxb_q   <= sxb_c;
      syb_q   <= syb_c;
      axb_q   <= axb_c;
      ayb_q   <= ayb_c;
      mb_q    <= m_c;
    end
  end

  // divider row for the rescaled length
  logic            d1_v    [0:F];
  logic [IW-1:0]   d1_rem  [0:F];
  logic [F-1:0]    d1_num  [0:F];
  logic [IW-1:0]   d1_den  [0:F];
  logic [F-1:0]    d1_quo  [0:F];
  logic [D1SW-1:0] d1_side [0:F];

  assign d1_v[0]    = vb_q;
  assign d1_rem[0]  = nb_q;
  assign d1_num[0]  = '0;
  assign d1_den[0]  = db_q;
  assign d1_quo[0]  = '0;
  assign d1_side[0] = {dzb_q, fullb_q, sxb_q, syb_q, axb_q, ayb_q, mb_q};

  for (genvar i = 0; i < F; i++) begin : g_div1
    srda_div_cell #(.DW(IW), .NW(F), .QW(F), .SW(D1SW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d1_v[i]), .rem_i(d1_rem[i]), .num_i(d1_num[i]),
      .den_i(d1_den[i]), .quo_i(d1_quo[i]), .side_i(d1_side[i]),
      .valid_o(d1_v[i+1]), .rem_o(d1_rem[i+1]), .num_o(d1_num[i+1]),
      .den_o(d1_den[i+1]), .quo_o(d1_quo[i+1]), .side_o(d1_side[i+1])
    );
  end

  // stage c: curve numerator and denominator
  logic           dzc_c, fullc_c, sxc_c, syc_c;
  logic [N-1:0]   axc_c, ayc_c, mc_c, b_c;
  logic [DW2-1:0] bpa_c;
  logic [PW-1:0]  p_c;
  logic           vc_q, dzc_q, sxc_q, syc_q;
  logic [N-1:0]   axc_q, ayc_q, mc_q, bc_q;
  logic [PW-1:0]  pc_q;
  logic [DW2-1:0] dc_q;

  assign {dzc_c, fullc_c, sxc_c, syc_c, axc_c, ayc_c, mc_c} = d1_side[F];
  assign b_c   = fullc_c ? ONE : {1'b0, d1_quo[F]};
  assign bpa_c = DW2'(b_c) + DW2'(aq);
  assign p_c   = b_c * bpa_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= d1_v[F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dzc_q <= dzc_c;
      sxc_q <= sxc_c;
      syc_q <= syc_c;
      axc_q <= axc_c;
      ayc_q <= ayc_c;
      mc_q  <= mc_c;
      bc_q  <= b_c;
      pc_q  <= p_c;
      dc_q  <= ONE_W + DW2'(aq);
    end
  end

  // divider row for the curve
  logic            d2_v    [0:N];
  logic [DW2-1:0]  d2_rem  [0:N];
  logic [N-1:0]    d2_num  [0:N];
  logic [DW2-1:0]  d2_den  [0:N];
  logic [N-1:0]    d2_quo  [0:N];
  logic [D2SW-1:0] d2_side [0:N];

  assign d2_v[0]    = vc_q;
  assign d2_rem[0]  = pc_q[PW-1:N];
  assign d2_num[0]  = pc_q[N-1:0];
  assign d2_den[0]  = dc_q;
  assign d2_quo[0]  = '0;
  assign d2_side[0] = {dzc_q, sxc_q, syc_q, axc_q, ayc_q, mc_q, bc_q};

  for (genvar i = 0; i < N; i++) begin : g_div2
    srda_div_cell #(.DW(DW2), .NW(N), .QW(N), .SW(D2SW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(d2_v[i]), .rem_i(d2_rem[i]), .num_i(d2_num[i]),
      .den_i(d2_den[i]), .quo_i(d2_quo[i]), .side_i(d2_side[i]),
      .valid_o(d2_v[i+1]), .rem_o(d2_rem[i+1]), .num_o(d2_num[i+1]),
      .den_o(d2_den[i+1]), .quo_o(d2_quo[i+1]), .side_o(d2_side[i+1])
    );
  end

  // stage e: axis products with the curved length
  logic           dze_c, sxe_c, sye_c;
  logic [N-1:0]   axe_c, aye_c, me_c, be_c, c_c;
  logic           ve_q, dze_q, sxe_q, sye_q;
  logic [N-1:0]   me_q, be_q, ce_q;
  logic [2*N-1:0] pxe_q, pye_q;

  assign {dze_c, sxe_c, sye_c, axe_c, aye_c, me_c, be_c} = d2_side[N];
  assign c_c = d2_quo[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= d2_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dze_q <= dze_c;
      sxe_q <= sxe_c;
      sye_q <= sye_c;
      me_q  <= me_c;
      be_q  <= be_c;
      ce_q  <= c_c;
      pxe_q <= axe_c * c_c;
      pye_q <= aye_c * c_c;
    end
  end

  // divider rows for the two axes
  logic            dx_v    [0:N];
  logic [N-1:0]    dx_rem  [0:N];
  logic [N-1:0]    dx_num  [0:N];
  logic [N-1:0]    dx_den  [0:N];
  logic [N-1:0]    dx_quo  [0:N];
  logic [D3SW-1:0] dx_side [0:N];
  logic            dy_v    [0:N];
  logic [N-1:0]    dy_rem  [0:N];
  logic [N-1:0]    dy_num  [0:N];
  logic [N-1:0]    dy_den  [0:N];
  logic [N-1:0]    dy_quo  [0:N];
  logic            dy_side [0:N];

  assign dx_v[0]    = ve_q;
  assign dx_rem[0]  = pxe_q[2*N-1:N];
  assign dx_num[0]  = pxe_q[N-1:0];
  assign dx_den[0]  = me_q;
  assign dx_quo[0]  = '0;
  assign dx_side[0] = {dze_q, sxe_q, be_q, ce_q};
  assign dy_v[0]    = ve_q;
  assign dy_rem[0]  = pye_q[2*N-1:N];
  assign dy_num[0]  = pye_q[N-1:0];
  assign dy_den[0]  = me_q;
  assign dy_quo[0]  = '0;
  assign dy_side[0] = sye_q;

  for (genvar i = 0; i < N; i++) begin : g_div3
    srda_div_cell #(.DW(N), .NW(N), .QW(N), .SW(D3SW)) u_cell_x (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dx_v[i]), .rem_i(dx_rem[i]), .num_i(dx_num[i]),
      .den_i(dx_den[i]), .quo_i(dx_quo[i]), .side_i(dx_side[i]),
      .valid_o(dx_v[i+1]), .rem_o(dx_rem[i+1]), .num_o(dx_num[i+1]),
      .den_o(dx_den[i+1]), .quo_o(dx_quo[i+1]), .side_o(dx_side[i+1])
    );
    srda_div_cell #(.DW(N), .NW(N), .QW(N), .SW(1)) u_cell_y (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dy_v[i]), .rem_i(dy_rem[i]), .num_i(dy_num[i]),
      .den_i(dy_den[i]), .quo_i(dy_quo[i]), .side_i(dy_side[i]),
      .valid_o(dy_v[i+1]), .rem_o(dy_rem[i+1]), .num_o(dy_num[i+1]),
      .den_o(dy_den[i+1]), .quo_o(dy_quo[i+1]), .side_o(dy_side[i+1])
    );
  end

  // output register: saturate, restore signs, zero inside deadzone
  logic         dzo_c, sxo_c;
  logic [N-1:0] bo_c, co_c, qx_s, qy_s, b_s, c_s;
  logic         out_vld_q;
  logic [N-1:0] out_x_q, out_y_q, mag_b_q, mag_c_q;

  assign {dzo_c, sxo_c, bo_c, co_c} = dx_side[N];
  assign qx_s = dx_quo[N][N-1] ? SAT : dx_quo[N];
  assign qy_s = dy_quo[N][N-1] ? SAT : dy_quo[N];
  assign b_s  = bo_c[N-1] ? SAT : bo_c;
  assign c_s  = co_c[N-1] ? SAT : co_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dx_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dzo_c) begin
        out_x_q <= '0;
        out_y_q <= '0;
        mag_b_q <= '0;
        mag_c_q <= '0;
      end else begin
        out_x_q <= sxo_c ? (~qx_s + N'(1)) : qx_s;
        out_y_q <= dy_side[N] ? (~qy_s + N'(1)) : qy_s;
        mag_b_q <= b_s;
        mag_c_q <= c_s;
      end
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.out_x            = out_x_q;
  assign out_o.out_y            = out_y_q;
  assign out_o.mag_before_accel = mag_b_q;
  assign out_o.mag_after_accel  = mag_c_q;

`ifndef SYNTHESIS
  logic [N-1:0] abs_x_o;
  assign abs_x_o = out_x_q[N-1] ? (~out_x_q + N'(1)) : out_x_q;

  // the two axis divider rows stay in step
  a_rows_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx_v[N] == dy_v[N])
    else $error("axis divider rows out of step");

  // the curve never lengthens the vector
  a_curve_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> mag_c_q <= mag_b_q)
    else $error("curved length exceeds rescaled length");

  // zero rescaled length gives a zero result
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && mag_b_q == '0 |-> mag_c_q == '0 && out_x_q == '0 && out_y_q == '0)
    else $error("nonzero output with zero length");

  // the horizontal axis never exceeds the curved length
  a_axis_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> abs_x_o <= mag_c_q)
    else $error("horizontal axis exceeds curved length");

  // a held result stays valid and keeps its curved length while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> $stable(mag_c_q) && out_vld_q)
    else $error("stalled result changed");
`endif

endmodule
